// File: sv/stl_pkg.sv
// Shared types, token kinds, lexer modes and keyword table for the source text lexer.
// Used by every module of the lexer; depends on nothing.
package stl_pkg;

   localparam int POS_BITS = 24;
   localparam int LINE_BITS = 20;
   localparam int KW_MAX_LEN = 11;
   localparam int KW_COUNT = 24;
   localparam int WLEN_BITS = $clog2(KW_MAX_LEN + 1);

   localparam logic [7:0] END_MARK = 8'd255;

   localparam logic [5:0] K_BANG = 6'd11;
   localparam logic [5:0] K_BANG_EQ = 6'd12;
   localparam logic [5:0] K_ARROW = 6'd15;
   localparam logic [5:0] K_SLASH = 6'd26;
   localparam logic [5:0] K_SLASH_EQ = 6'd27;
   localparam logic [5:0] K_STRING = 6'd28;
   localparam logic [5:0] K_NUMBER = 6'd29;
   localparam logic [5:0] K_IDENT = 6'd30;
   localparam logic [5:0] K_END = 6'd31;
   localparam logic [5:0] K_KW0 = 6'd32;
   localparam logic [5:0] K_ERR_CHAR = 6'd56;
   localparam logic [5:0] K_ERR_STR = 6'd57;

   typedef enum logic [3:0] {
      M_IDLE = 4'd0, M_BANG = 4'd1, M_EQ = 4'd2, M_GT = 4'd3, M_LT = 4'd4,
      M_MINUS = 4'd5, M_PLUS = 4'd6, M_STAR = 4'd7, M_SLASH = 4'd8,
      M_LCOMM = 4'd9, M_BCOMM = 4'd10, M_BSTAR = 4'd11, M_STR = 4'd12,
      M_INT = 4'd13, M_FRAC = 4'd14, M_IDENT = 4'd15
   } mode_type;

   typedef logic [7:0] word_type [KW_MAX_LEN];

   // One classified byte handed from the scanner to the emitter.
   typedef struct packed {
      logic                 tok0_valid;
      logic [5:0]           tok0_kind;
      logic                 tok0_is_word;
      logic [POS_BITS-1:0]  tok0_start;
      logic [POS_BITS-1:0]  tok0_end;
      logic [LINE_BITS-1:0] tok0_line;
      logic                 tok1_valid;
      logic [5:0]           tok1_kind;
      logic [POS_BITS-1:0]  tok1_start;
      logic [POS_BITS-1:0]  tok1_end;
      logic [LINE_BITS-1:0] tok1_line;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   function automatic logic [8*KW_MAX_LEN-1:0] kw_text(input int k);
      logic [8*KW_MAX_LEN-1:0] t;
      t = '0;
      case (k)
         0: t[23:0] = "dna";
         1: t[39:0] = "ssalc";
         2: t[39:0] = "tsnoc";
         3: t[31:0] = "esle";
         4: t[39:0] = "eslaf";
         5: t[31:0] = "cnuf";
         6: t[23:0] = "rof";
         7: t[15:0] = "fi";
         8: t[23:0] = "lin";
         9: t[15:0] = "ro";
         10: t[39:0] = "tnirp";
         11: t[47:0] = "nruter";
         12: t[39:0] = "repus";
         13: t[31:0] = "siht";
         14: t[31:0] = "eurt";
         15: t[23:0] = "rav";
         16: t[39:0] = "elihw";
         17: t[47:0] = "taeper";
         18: t[47:0] = "rebmem";
         19: t[47:0] = "dohtem";
         20: t[87:0] = "rotcurtsnoc";
         21: t[39:0] = "niahc";
         22: t[31:0] = "htiw";
         23: t[39:0] = "kaerb";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [WLEN_BITS-1:0] kw_len(input int k);
      logic [WLEN_BITS-1:0] l;
      case (k)
         7, 9: l = WLEN_BITS'(2);
         0, 6, 8, 15: l = WLEN_BITS'(3);
         3, 5, 13, 14, 22: l = WLEN_BITS'(4);
         11, 17, 18, 19: l = WLEN_BITS'(6);
         20: l = WLEN_BITS'(11);
         default: l = WLEN_BITS'(5);
      endcase
      return l;
   endfunction

   function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] p);
      return (&p) ? p : p + POS_BITS'(1);
   endfunction

endpackage

// File: sv/stl_if.sv
// Valid/ready channel interfaces for the lexer's byte input and token output.
// Depends on stl_pkg.
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

interface stl_rsp_if;
   import stl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [5:0]           token_kind;
   logic [POS_BITS-1:0]  token_start;
   logic [POS_BITS-1:0]  token_end;
   logic [LINE_BITS-1:0] line_number;
   logic                 last_of_run;
   modport source (output valid, output token_kind, output token_start, output token_end,
                   output line_number, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start, input token_end,
                 input line_number, input last_of_run, output ready);
endinterface

// File: sv/stl_scan.sv
// Front end: takes one byte a cycle while take is high, updates the lexer mode and
// counters, and produces up to two raw tokens per byte. Depends on stl_pkg.
module stl_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [7:0]               in_byte,
   input  logic                     take,
   output stl_pkg::entry_type       entry,
   output logic [8*stl_pkg::KW_MAX_LEN-1:0] word_flat,
   output logic [stl_pkg::WLEN_BITS-1:0]    word_len,
   output logic                     word_long
);
   import stl_pkg::*;

   mode_type             mode_ff, mode_in;
   logic [POS_BITS-1:0]  start_ff, start_in;
   logic [POS_BITS-1:0]  pos_ff;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [7:0]           word_ff [KW_MAX_LEN];
   logic [WLEN_BITS-1:0] wlen_ff, wlen_in;
   logic                 wlong_ff, wlong_in;
   logic                 wr_en;
   logic [WLEN_BITS-1:0] wr_idx;

   logic [POS_BITS-1:0]  pos, pos1;
   logic                 is_digit, is_alpha;
   mode_type             idle_mode;
   logic                 idle_emit, idle_nl, idle_word;
   logic [5:0]           idle_kind;
   logic [POS_BITS-1:0]  idle_end;
   logic [LINE_BITS-1:0] line_inc;

   assign pos = pos_ff;
   assign pos1 = pos_inc(pos_ff);
   assign is_digit = in_byte >= "0" && in_byte <= "9";
   assign is_alpha = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
   assign line_inc = (&line_ff) ? line_ff : line_ff + LINE_BITS'(1);

   // Decode of a byte seen from the idle mode.
   always_comb begin
      idle_mode = M_IDLE;
      idle_emit = 1'b1;
      idle_nl = 1'b0;
      idle_word = 1'b0;
      idle_kind = K_ERR_CHAR;
      idle_end = pos1;
      case (in_byte)
         "\n": begin idle_emit = 1'b0; idle_nl = 1'b1; end
         "\r", "\t", " ": idle_emit = 1'b0;
         "(": idle_kind = 6'd0;
         ")": idle_kind = 6'd1;
         "{": idle_kind = 6'd2;
         "}": idle_kind = 6'd3;
         "[": idle_kind = 6'd4;
         "]": idle_kind = 6'd5;
         ",": idle_kind = 6'd6;
         ".": idle_kind = 6'd7;
         ";": idle_kind = 6'd8;
         "?": idle_kind = 6'd9;
         ":": idle_kind = 6'd10;
         "!": begin idle_emit = 1'b0; idle_mode = M_BANG; end
         "=": begin idle_emit = 1'b0; idle_mode = M_EQ; end
         ">": begin idle_emit = 1'b0; idle_mode = M_GT; end
         "<": begin idle_emit = 1'b0; idle_mode = M_LT; end
         "-": begin idle_emit = 1'b0; idle_mode = M_MINUS; end
         "+": begin idle_emit = 1'b0; idle_mode = M_PLUS; end
         "*": begin idle_emit = 1'b0; idle_mode = M_STAR; end
         "/": begin idle_emit = 1'b0; idle_mode = M_SLASH; end
         "\"": begin idle_emit = 1'b0; idle_mode = M_STR; end
         END_MARK: begin idle_kind = K_END; idle_end = pos; end
         default: begin
            if (is_digit) begin
               idle_emit = 1'b0;
               idle_mode = M_INT;
            end else if (is_alpha) begin
               idle_emit = 1'b0;
               idle_mode = M_IDENT;
               idle_word = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      logic use_idle;
      logic t0;
      logic [5:0] k0;
      logic [POS_BITS-1:0] s0, e0;
      logic nl;
      use_idle = 1'b0;
      t0 = 1'b0;
      k0 = K_IDENT;
      s0 = start_ff;
      e0 = pos;
      nl = 1'b0;
      mode_in = mode_ff;
      wlen_in = wlen_ff;
      wlong_in = wlong_ff;
      wr_en = 1'b0;
      wr_idx = wlen_ff;
      entry = '0;
      entry.tok0_is_word = 1'b0;
      case (mode_ff)
         M_BANG, M_EQ, M_GT, M_LT, M_MINUS, M_PLUS, M_STAR: begin
            // Kinds come in single and '=' pairs; the arrow kind sits after the '=' pair,
            // so the pairs from '>' on are shifted up by one.
            t0 = 1'b1;
            if (in_byte == "=") begin
               k0 = K_BANG + 6'({mode_ff, 1'b0}) - 6'd1 + 6'(mode_ff >= M_GT);
               e0 = pos1;
               mode_in = M_IDLE;
            end else if (mode_ff == M_EQ && in_byte == ">") begin
               k0 = K_ARROW;
               e0 = pos1;
               mode_in = M_IDLE;
            end else begin
               k0 = K_BANG + 6'({mode_ff, 1'b0}) - 6'd2 + 6'(mode_ff >= M_GT);
               use_idle = 1'b1;
            end
         end
         M_SLASH: begin
            if (in_byte == "/") mode_in = M_LCOMM;
            else if (in_byte == "*") mode_in = M_BCOMM;
            else if (in_byte == "=") begin
               t0 = 1'b1; k0 = K_SLASH_EQ; e0 = pos1; mode_in = M_IDLE;
            end else begin
               t0 = 1'b1; k0 = K_SLASH; use_idle = 1'b1;
            end
         end
         M_LCOMM: begin
            if (in_byte == "\n") begin nl = 1'b1; mode_in = M_IDLE; end
            else if (in_byte == END_MARK) use_idle = 1'b1;
         end
         M_BCOMM, M_BSTAR: begin
            if (in_byte == END_MARK) use_idle = 1'b1;
            else if (in_byte == "/" && mode_ff == M_BSTAR) mode_in = M_IDLE;
            else if (in_byte == "*") mode_in = M_BSTAR;
            else begin
               nl = (in_byte == "\n");
               mode_in = M_BCOMM;
            end
         end
         M_STR: begin
            if (in_byte == "\"") begin
               t0 = 1'b1; k0 = K_STRING; s0 = pos_inc(start_ff); mode_in = M_IDLE;
            end else if (in_byte == END_MARK) begin
               t0 = 1'b1; k0 = K_ERR_STR; use_idle = 1'b1;
            end
         end
         M_INT, M_FRAC: begin
            if (is_digit) begin
               mode_in = mode_ff;
            end else if (in_byte == "." && mode_ff == M_INT) begin
               mode_in = M_FRAC;
            end else begin
               t0 = 1'b1; k0 = K_NUMBER; use_idle = 1'b1;
            end
         end
         M_IDENT: begin
            if (is_alpha || is_digit || in_byte == "_") begin
               if (wlen_ff < WLEN_BITS'(KW_MAX_LEN)) begin
                  wr_en = 1'b1;
                  wlen_in = wlen_ff + WLEN_BITS'(1);
               end else begin
                  wlong_in = 1'b1;
               end
            end else begin
               t0 = 1'b1; k0 = K_IDENT; use_idle = 1'b1;
               entry.tok0_is_word = 1'b1;
            end
         end
         default: use_idle = 1'b1;
      endcase

      start_in = start_ff;
      if (use_idle) begin
         mode_in = idle_mode;
         start_in = pos;
         nl = idle_nl;
         if (idle_word) begin
            wr_en = 1'b1;
            wr_idx = '0;
            wlen_in = WLEN_BITS'(1);
            wlong_in = 1'b0;
         end
      end
      line_in = nl ? line_inc : line_ff;

      entry.tok0_valid = t0 || (use_idle && idle_emit);
      entry.tok1_valid = t0 && use_idle && idle_emit;
      if (t0) begin
         entry.tok0_kind = k0;
         entry.tok0_start = s0;
         entry.tok0_end = e0;
      end else begin
         entry.tok0_kind = idle_kind;
         entry.tok0_start = pos;
         entry.tok0_end = idle_end;
      end
      entry.tok0_line = line_ff;
      entry.tok1_kind = idle_kind;
      entry.tok1_start = pos;
      entry.tok1_end = idle_end;
      entry.tok1_line = line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         start_ff <= '0;
         pos_ff <= '0;
         line_ff <= '0;
         wlen_ff <= '0;
         wlong_ff <= 1'b0;
      end else if (in_valid && take) begin
         mode_ff <= mode_in;
         start_ff <= start_in;
         pos_ff <= pos1;
         line_ff <= line_in;
         wlen_ff <= wlen_in;
         wlong_ff <= wlong_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && take && wr_en) word_ff[wr_idx[WLEN_BITS-1:0]] <= in_byte;
   end

   always_comb begin
      for (int i = 0; i < KW_MAX_LEN; i++) word_flat[8*i +: 8] = word_ff[i];
   end
   assign word_len = wlen_ff;
   assign word_long = wlong_ff;
endmodule

// File: sv/stl_kwmatch.sv
// Keyword matcher: compares the buffered identifier against all keywords in parallel.
// Depends on stl_pkg.
module stl_kwmatch (
   input  logic                             clock,
   input  logic [8*stl_pkg::KW_MAX_LEN-1:0] word_flat,
   input  logic [stl_pkg::WLEN_BITS-1:0]    word_len,
   input  logic                             word_long,
   input  logic                             load,
   output logic [5:0]                       word_kind
);
   import stl_pkg::*;

   logic [5:0] kind_in, kind_ff;

   always_comb begin
      logic [8*KW_MAX_LEN-1:0] mask;
      kind_in = K_IDENT;
      mask = '0;
      for (int i = 0; i < KW_MAX_LEN; i++) mask[8*i +: 8] = (i < int'(word_len)) ? 8'hFF : 8'h00;
      if (!word_long) begin
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_len(k) == word_len && (word_flat & mask) == kw_text(k))
               kind_in = K_KW0 + 6'(k);
         end
      end
   end

   // Registered alongside the queue entry so the compare stays off the output path.
   always_ff @(posedge clock) begin
      if (load) kind_ff <= kind_in;
   end
   assign word_kind = kind_ff;
endmodule

// File: sv/stl_emit.sv
// Back end: a two-entry queue of classified bytes that serializes up to two
// tokens per entry onto the result channel. Depends on stl_pkg.
module stl_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stl_pkg::entry_type push_entry,
   input  logic [5:0]         word_kind,
   output logic               full,
   stl_rsp_if.source          rsp
);
   import stl_pkg::*;

   entry_type  q_ff [2];
   logic [5:0] wk_ff [2];
   logic       wp_ff, rp_ff, half_ff;
   logic [1:0] cnt_ff;
   entry_type  head;
   logic       pop, adv, has_tok;

   assign head = q_ff[rp_ff];
   assign full = cnt_ff == 2'd2;
   assign has_tok = head.tok0_valid && cnt_ff != 2'd0;

   // Entries with no token are dropped without a beat.
   assign rsp.valid = has_tok;
   always_comb begin
      if (half_ff) begin
         rsp.token_kind = head.tok1_kind;
         rsp.token_start = head.tok1_start;
         rsp.token_end = head.tok1_end;
         rsp.line_number = head.tok1_line;
         rsp.last_of_run = 1'b1;
      end else begin
         rsp.token_kind = head.tok0_is_word ? wk_ff[rp_ff] : head.tok0_kind;
         rsp.token_start = head.tok0_start;
         rsp.token_end = head.tok0_end;
         rsp.line_number = head.tok0_line;
         rsp.last_of_run = !head.tok1_valid;
      end
   end

   assign adv = has_tok && rsp.ready;
   assign pop = (cnt_ff != 2'd0) && (!head.tok0_valid || (adv && rsp.last_of_run));

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         half_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
         if (pop) half_ff <= 1'b0;
         else if (adv) half_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_entry;
         wk_ff[wp_ff] <= word_kind;
      end
   end
endmodule

// File: sv/source_text_lexer_top.sv
// Source text lexer top level: scanner front end, keyword matcher and token queue.
// Path: a token passes the stage register and then the queue before it is valid on rsp.
// Throughput: one byte per cycle while req.ready is high; a byte that yields two tokens
// takes two output beats. The two-entry queue lets the scanner keep accepting while the
// output stalls, until the queue and the stage register are full.
// Reset (synchronous, active high) returns to idle mode with offset and line at zero.
module source_text_lexer_top (
   input logic       clock,
   input logic       reset,
   stl_req_if.sink   req,
   stl_rsp_if.source rsp
);
   import stl_pkg::*;

   entry_type               entry, entry_ff;
   logic                    entry_valid_ff;
   logic [8*KW_MAX_LEN-1:0] word_flat;
   logic [WLEN_BITS-1:0]    word_len;
   logic                    word_long;
   logic [5:0]              word_kind;
   logic                    full, stage_free;

   // Stage register between scanner and queue; it moves on when it is empty or the queue has room.
   assign stage_free = !entry_valid_ff || !full;
   assign req.ready = stage_free;

   stl_scan u_scan (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_byte(req.char_byte),
      .take(stage_free), .entry(entry), .word_flat(word_flat), .word_len(word_len),
      .word_long(word_long)
   );

   stl_kwmatch u_kw (
      .clock(clock), .word_flat(word_flat), .word_len(word_len), .word_long(word_long),
      .load(stage_free), .word_kind(word_kind)
   );

   always_ff @(posedge clock) begin
      if (reset) entry_valid_ff <= 1'b0;
      else if (stage_free) entry_valid_ff <= req.valid;
   end
   always_ff @(posedge clock) begin
      if (stage_free) entry_ff <= entry;
   end

   stl_emit u_emit (
      .clock(clock), .reset(reset), .push(entry_valid_ff && !full), .push_entry(entry_ff),
      .word_kind(word_kind), .full(full), .rsp(rsp)
   );
endmodule

// File: sv/stl_checker.sv
// Port-level checker for the lexer top level, attached with bind.
// Depends on stl_pkg.
module stl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [5:0]                     rsp_kind,
   input logic [stl_pkg::POS_BITS-1:0]   rsp_start,
   input logic [stl_pkg::POS_BITS-1:0]   rsp_end,
   input logic                           rsp_last
);
   import stl_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("token changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= K_ERR_STR)
      else $error("token kind out of range");

   a_end_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != K_STRING |-> rsp_start <= rsp_end)
      else $error("token ends before it starts");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == K_END |-> rsp_last && rsp_start == rsp_end)
      else $error("malformed end token");
endmodule

bind source_text_lexer_top stl_checker u_stl_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.token_kind), .rsp_start(rsp.token_start), .rsp_end(rsp.token_end),
   .rsp_last(rsp.last_of_run)
);
